@@ rtl/pll_pkg.sv @@
// Package for the pooled linked list engine: sizes, command codes, control types.
package pll_pkg;

  localparam int POOL_SLOTS = 32;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_FRONT = 2'd0,
    CMD_REMOVE_FRONT = 2'd1,
    CMD_FIND         = 2'd2,
    CMD_REMOVE_VALUE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WORK = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;   // shift toward tail, new value enters cell 0
    logic pop;    // cells at/after the search point take from their right neighbor
    logic step;   // search token moves one cell toward the tail
    logic seed;   // token enters cell 0 (together with step)
    logic clear;  // drop token, reopen the tail mask
  } cell_ctl_t;

  // status returned by the chain
  typedef struct packed {
    logic                     any_hit;
    logic                     at_end;
    logic                     any_tok;
    logic                     head_vld;
    logic signed [DATA_W-1:0] head_data;
  } chain_sts_t;

endpackage

@@ rtl/pll_cell.sv @@
// One list position: value, occupancy, search token and tail-mask bit.
module pll_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pll_pkg::cell_ctl_t               ctl_i,
  input  logic signed [pll_pkg::DATA_W-1:0] key_i,
  input  logic signed [pll_pkg::DATA_W-1:0] left_data_i,
  input  logic                             left_vld_i,
  input  logic                             left_tok_i,
  input  logic signed [pll_pkg::DATA_W-1:0] right_data_i,
  input  logic                             right_vld_i,
  output logic signed [pll_pkg::DATA_W-1:0] data_o,
  output logic                             vld_o,
  output logic                             tok_o,
  output logic                             hit_o,
  output logic                             end_o
);
  import pll_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     vld_q, vld_d;
  logic                     tok_q, tok_d;
  logic                     tail_q, tail_d;

  always_comb begin
    data_d = data_q;
    vld_d  = vld_q;
    tok_d  = tok_q;
    tail_d = tail_q;
    if (ctl_i.push) begin
      data_d = left_data_i;
      vld_d  = left_vld_i;
    end else if (ctl_i.pop && tail_q) begin
      data_d = right_data_i;
      vld_d  = right_vld_i;
    end
    if (ctl_i.clear) begin
      tok_d  = 1'b0;
      tail_d = 1'b1;
    end else if (ctl_i.step) begin
      tok_d  = left_tok_i;
      tail_d = tail_q & ~tok_q;  // positions the token has passed drop out
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      tok_q  <= 1'b0;
      tail_q <= 1'b1;
    end else begin
      vld_q  <= vld_d;
      tok_q  <= tok_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign vld_o  = vld_q;
  assign tok_o  = tok_q;
  assign hit_o  = tok_q & vld_q & (data_q == key_i);
  assign end_o  = tok_q & ~vld_q;

endmodule

@@ rtl/pll_chain.sv @@
// Row of list cells, head at cell 0, with status reduction.
module pll_chain (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pll_pkg::cell_ctl_t               ctl_i,
  input  logic signed [pll_pkg::DATA_W-1:0] key_i,
  output pll_pkg::chain_sts_t              sts_o,
  output logic [pll_pkg::POOL_SLOTS-1:0]   vld_o
);
  import pll_pkg::*;

  logic signed [DATA_W-1:0] data_w [POOL_SLOTS];
  logic [POOL_SLOTS-1:0]    vld_w;
  logic [POOL_SLOTS-1:0]    tok_w;
  logic [POOL_SLOTS-1:0]    hit_w;
  logic [POOL_SLOTS-1:0]    end_w;

  for (genvar j = 0; j < POOL_SLOTS; j++) begin : g_cell
    logic signed [DATA_W-1:0] l_data;
    logic                     l_vld;
    logic                     l_tok;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_vld;

    if (j == 0) begin : g_head
      assign l_data = key_i;
      assign l_vld  = 1'b1;
      assign l_tok  = ctl_i.seed;
    end else begin : g_mid
      assign l_data = data_w[j-1];
      assign l_vld  = vld_w[j-1];
      assign l_tok  = tok_w[j-1];
    end

    if (j == POOL_SLOTS - 1) begin : g_last
      assign r_data = '0;
      assign r_vld  = 1'b0;
    end else begin : g_inner
      assign r_data = data_w[j+1];
      assign r_vld  = vld_w[j+1];
    end

    pll_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_i),
      .key_i        (key_i),
      .left_data_i  (l_data),
      .left_vld_i   (l_vld),
      .left_tok_i   (l_tok),
      .right_data_i (r_data),
      .right_vld_i  (r_vld),
      .data_o       (data_w[j]),
      .vld_o        (vld_w[j]),
      .tok_o        (tok_w[j]),
      .hit_o        (hit_w[j]),
      .end_o        (end_w[j])
    );
  end

  // token falling off the last cell also ends the walk
  assign sts_o.any_hit   = |hit_w;
  assign sts_o.at_end    = (|end_w) | ~(|tok_w);
  assign sts_o.any_tok   = |tok_w;
  assign sts_o.head_vld  = vld_w[0];
  assign sts_o.head_data = data_w[0];
  assign vld_o           = vld_w;

endmodule

@@ rtl/pooled_linked_list_engine.sv @@
// Top level of the pooled linked list engine: command sequencer and result register.
// Usage:
//   Input channel: cmd_i / operand_value_i with in_valid_i, stalled by in_stall_o.
//   A transaction is taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: ok_o / front_value_o / entry_count_out_o with out_valid_o,
//   stalled by out_stall_i. Exactly one result transaction per command, in order.
// Sequencing:
//   Insert front and remove front finish without a walk; the command is registered
//   at the input edge and the result is loaded into the output register from the
//   work state when that register is free. Find and remove value walk the list one
//   cell per cycle, ending at a match, at the first empty cell or past the last cell.
//   The walk length is set by the search token stepping along the cell row.
//   One command is in flight at a time; in_stall_o stays high until the result
//   has moved into the output register and drops at that same edge.
// Reset: list empty, count zero, no result pending.
// Receiver stall: a finished result waits in a hold register until the output
//   register drains; no new command is taken while it waits.
module pooled_linked_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pll_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [pll_pkg::DATA_W-1:0] operand_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [pll_pkg::DATA_W-1:0] front_value_o,
  output logic [pll_pkg::CNT_W-1:0]         entry_count_out_o
);
  import pll_pkg::*;

  state_e                   state_q, state_d;
  cmd_e                     cmd_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count_q, count_d;

  // result held when the output register is still occupied
  logic                     hold_ok_q;
  logic signed [DATA_W-1:0] hold_front_q;
  logic [CNT_W-1:0]         hold_cnt_q;

  logic                     out_vld_q;
  logic                     out_ok_q;
  logic signed [DATA_W-1:0] out_front_q;
  logic [CNT_W-1:0]         out_cnt_q;

  cell_ctl_t                ctl;
  chain_sts_t               sts;
  logic [POOL_SLOTS-1:0]    cell_vld;

  logic                     accept;
  logic                     out_free;
  logic                     fin;
  logic                     res_ok;
  logic signed [DATA_W-1:0] res_front;
  logic                     load_out;
  logic                     load_hold;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_vld_q | ~out_stall_i;

  pll_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .key_i  (key_q),
    .sts_o  (sts),
    .vld_o  (cell_vld)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ctl       = '0;
    fin       = 1'b0;
    res_ok    = 1'b0;
    res_front = '0;
    load_out  = 1'b0;
    load_hold = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // token enters at the head; harmless for the non-walking commands
          ctl.step = 1'b1;
          ctl.seed = 1'b1;
          state_d  = ST_WORK;
        end
      end
      ST_WORK: begin
        case (cmd_q)
          CMD_INSERT_FRONT: begin
            fin = 1'b1;
            if (count_q < CNT_W'(POOL_SLOTS)) begin
              ctl.push = 1'b1;
              res_ok   = 1'b1;
              count_d  = count_q + 1'b1;
            end
          end
          CMD_REMOVE_FRONT: begin
            fin = 1'b1;
            if (sts.head_vld) begin
              ctl.pop   = 1'b1;  // tail mask is all ones here
              res_ok    = 1'b1;
              res_front = sts.head_data;
              count_d   = count_q - 1'b1;
            end
          end
          CMD_FIND, CMD_REMOVE_VALUE: begin
            if (sts.any_hit) begin
              fin    = 1'b1;
              res_ok = 1'b1;
              if (cmd_q == CMD_REMOVE_VALUE) begin
                ctl.pop = 1'b1;  // close the gap behind the matching cell
                count_d = count_q - 1'b1;
              end
            end else if (sts.at_end) begin
              fin = 1'b1;
            end else begin
              ctl.step = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          ctl.clear = 1'b1;
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            load_hold = 1'b1;
            state_d   = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= load_out | (out_vld_q & out_stall_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= operand_value_i;
    end
    if (load_hold) begin
      hold_ok_q    <= res_ok;
      hold_front_q <= res_front;
      hold_cnt_q   <= count_d;
    end
    if (load_out) begin
      if (state_q == ST_HOLD) begin
        out_ok_q    <= hold_ok_q;
        out_front_q <= hold_front_q;
        out_cnt_q   <= hold_cnt_q;
      end else begin
        out_ok_q    <= res_ok;
        out_front_q <= res_front;
        out_cnt_q   <= count_d;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign ok_o              = out_ok_q;
  assign front_value_o     = out_front_q;
  assign entry_count_out_o = out_cnt_q;

`ifndef SYNTH
  // occupied cells and the entry counter agree
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(count_q))
    else $error("entry count differs from occupied cells");

  // a search token exists only while a command is being worked on
  a_no_stray_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WORK) |-> !sts.any_tok)
    else $error("search token alive outside a command");

  // a failed command never reports a front value
  a_fail_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (front_value_o == '0))
    else $error("front value set on a failed command");
`endif

endmodule
